### hdl/ecbs_pkg.sv
package ecbs_pkg;

    localparam int TIME_W = 48;
    localparam int TAG_W  = 8;
    localparam int PEND_W = 16;

    localparam logic [PEND_W-1:0] PEND_MAX = '1;

    // add status codes
    localparam logic [1:0] ADD_NONE = 2'd0;
    localparam logic [1:0] ADD_OK   = 2'd1;
    localparam logic [1:0] ADD_FULL = 2'd2;

    typedef enum logic [2:0] {
        F_ADD,
        F_REMOVE,
        F_READY,
        F_BLOCK,
        F_END_JOB,
        F_BUDGET_OUT,
        F_NEW_JOB,
        F_TIMEOUT
    } t_func;

    typedef enum logic [1:0] {
        M_ACTIVE,
        M_BLOCKED,
        M_TIMED,
        M_IDLE
    } t_mode;

    typedef struct packed {
        t_func             func;
        logic [TIME_W-1:0] now;
        logic [TAG_W-1:0]  task_tag;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] rel_deadline;
        logic [TIME_W-1:0] max_budget;
        logic              is_server;
    } t_req;

    typedef struct packed {
        logic [1:0]        add_status;
        logic              deadline_missed;
        logic              next_valid;
        logic [TAG_W-1:0]  next_tag;
        logic              suspend_valid;
        logic [TAG_W-1:0]  suspend_tag;
        logic              start_valid;
        logic [TIME_W-1:0] wake_time;
        logic              rearm_valid;
        logic [TIME_W-1:0] rearm_budget;
    } t_rsp;

    // one row of the task table
    typedef struct packed {
        logic [TAG_W-1:0]  tag;
        t_mode             mode;
        logic [TIME_W-1:0] period;
        logic [TIME_W-1:0] abs_dl;
        logic [TIME_W-1:0] abs_start;
        logic              is_server;
        logic [TIME_W-1:0] max_budget;
        logic [PEND_W-1:0] pending;
    } t_entry;

    // controller -> datapath
    typedef struct packed {
        logic load;
        logic look;
        logic apply;
        logic shift;
        logic scan;
        logic fin;
        logic ev_v;
    } t_ctl;

    // datapath -> controller
    typedef struct packed {
        logic hit;
        logic key_valid;
        logic shrink;
        logic out_free;
    } t_sts;

endpackage

### hdl/ecbs_ram.sv
module ecbs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hdl/ecbs_ctrl.sv
module ecbs_ctrl #(
    parameter int MAX_TASKS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_req_valid,
    output logic                                 o_req_ready,
    input  ecbs_pkg::t_sts                       i_sts,
    input  logic [$clog2(MAX_TASKS+1)-1:0]       i_cnt,
    input  logic [$clog2(MAX_TASKS)-1:0]         i_kidx,
    output ecbs_pkg::t_ctl                       o_ctl,
    output logic [$clog2(MAX_TASKS)-1:0]         o_raddr,
    output logic [$clog2(MAX_TASKS+1)-1:0]       o_pidx
);
    import ecbs_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_LOOK,
        S_APPLY,
        S_SHIFT,
        S_SCAN,
        S_FIN
    } t_state;

    t_state        r_state, n_state;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pidx, n_pidx;
    logic          r_pv, n_pv;
    logic          issue;

    // read issue condition per phase
    always_comb begin
        case (r_state)
            S_LOOK:  issue = i_sts.key_valid && (r_idx < i_cnt);
            S_SHIFT: issue = (r_idx <= i_cnt);
            S_SCAN:  issue = (r_idx < i_cnt);
            default: issue = 1'b0;
        endcase
    end

    // next state and walk counters
    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        n_pidx  = r_pidx;
        n_pv    = 1'b0;
        if (issue) begin
            n_pv   = 1'b1;
            n_pidx = r_idx;
            n_idx  = r_idx + CW'(1);
        end
        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_state = S_LOOK;
                    n_idx   = '0;
                end
            end
            S_LOOK: begin
                if ((r_pv && i_sts.hit) || (!issue && !r_pv)) begin
                    n_state = S_APPLY;
                    n_pv    = 1'b0;
                end
            end
            S_APPLY: begin
                n_pv = 1'b0;
                if (i_sts.shrink) begin
                    n_state = S_SHIFT;
                    n_idx   = CW'(i_kidx) + CW'(1);
                end else begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SHIFT: begin
                if (!issue && !r_pv) begin
                    n_state = S_SCAN;
                    n_idx   = '0;
                end
            end
            S_SCAN: begin
                if (!issue && !r_pv) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_pidx  <= '0;
            r_pv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_pidx  <= n_pidx;
            r_pv    <= n_pv;
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_raddr     = r_idx[IW-1:0];
    assign o_pidx      = r_pidx;

    always_comb begin
        o_ctl.load  = (r_state == S_IDLE) && i_req_valid;
        o_ctl.look  = (r_state == S_LOOK);
        o_ctl.apply = (r_state == S_APPLY);
        o_ctl.shift = (r_state == S_SHIFT);
        o_ctl.scan  = (r_state == S_SCAN);
        o_ctl.fin   = (r_state == S_FIN) && i_sts.out_free;
        o_ctl.ev_v  = r_pv;
    end

    // read data in flight only during table walks
    a_pv_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> (r_state == S_LOOK || r_state == S_SHIFT || r_state == S_SCAN))
        else $error("read in flight outside a table walk");

    // a taken request starts a lookup with no read in flight
    a_load_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ctl.load |=> (r_state == S_LOOK) && !r_pv)
        else $error("request load did not start lookup");

    // a shift walk starts past the removed row
    a_shift_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_APPLY && i_sts.shrink) |=> (r_idx != '0))
        else $error("shift started at row zero");
endmodule

### hdl/ecbs_dpath.sv
module ecbs_dpath #(
    parameter int MAX_TASKS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  ecbs_pkg::t_ctl                       i_ctl,
    input  logic [$clog2(MAX_TASKS)-1:0]         i_raddr,
    input  logic [$clog2(MAX_TASKS+1)-1:0]       i_pidx,
    input  ecbs_pkg::t_req                       i_req,
    output ecbs_pkg::t_sts                       o_sts,
    output logic [$clog2(MAX_TASKS+1)-1:0]       o_cnt,
    output logic [$clog2(MAX_TASKS)-1:0]         o_kidx,
    output logic                                 o_rsp_valid,
    input  logic                                 i_rsp_ready,
    output ecbs_pkg::t_rsp                       o_rsp
);
    import ecbs_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);
    localparam int EW = $bits(t_entry);

    // latched request and persistent state
    t_req              r_req;
    logic [CW-1:0]     r_cnt;
    logic              r_run_v;
    logic [TAG_W-1:0]  r_run_tag;

    // lookup result
    logic              r_found;
    logic [IW-1:0]     r_kidx;
    t_entry            r_ent;

    // event results
    logic [1:0]        r_add_st;
    logic              r_missed;
    logic              r_rearm_v;
    logic [TIME_W-1:0] r_rearm_b;

    // scan accumulators
    logic              r_nv;
    logic [TAG_W-1:0]  r_nt;
    logic [TIME_W-1:0] r_bdl;
    logic              r_sv;
    logic [TIME_W-1:0] r_st;
    logic              r_rm_seen;
    logic              r_rm_blk;

    // output register
    logic              r_rsp_valid;
    t_rsp              r_rsp;

    // table port
    logic              we;
    logic [IW-1:0]     waddr;
    t_entry            wdata;
    logic [EW-1:0]     rdata;
    t_entry            rd;

    ecbs_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TASKS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_raddr),
        .o_rdata (rdata)
    );

    assign rd = t_entry'(rdata);

    // lookup key: request tag or running tag
    logic             tag_op, run_op, key_valid;
    logic [TAG_W-1:0] key;

    always_comb begin
        tag_op    = (r_req.func == F_REMOVE) || (r_req.func == F_READY) ||
                    (r_req.func == F_NEW_JOB);
        run_op    = (r_req.func == F_BLOCK) || (r_req.func == F_END_JOB) ||
                    (r_req.func == F_BUDGET_OUT);
        key_valid = tag_op || (run_op && r_run_v);
        key       = tag_op ? r_req.task_tag : r_run_tag;
    end

    // event applied to the found row
    t_entry            e_mod, e_new;
    logic              ap_missed, ap_rearm;
    logic [TIME_W-1:0] dl_adv, st_adv, now_per;
    logic [PEND_W-1:0] pend_dec;
    logic              table_full;

    always_comb begin
        dl_adv     = r_ent.abs_dl + r_ent.period;
        st_adv     = r_ent.abs_start + r_ent.period;
        now_per    = r_req.now + r_ent.period;
        pend_dec   = (r_ent.pending != '0) ? (r_ent.pending - PEND_W'(1)) : '0;
        e_mod      = r_ent;
        ap_missed  = 1'b0;
        ap_rearm   = 1'b0;
        table_full = (r_cnt >= CW'(MAX_TASKS));
        case (r_req.func)
            F_READY: e_mod.mode = M_ACTIVE;
            F_BLOCK: e_mod.mode = M_BLOCKED;
            F_END_JOB: begin
                ap_missed = (r_ent.abs_dl < r_req.now);
                if (r_ent.is_server) begin
                    e_mod.pending = pend_dec;
                    if (pend_dec == '0) begin
                        e_mod.mode      = M_IDLE;
                        e_mod.abs_start = st_adv;
                        e_mod.abs_dl    = dl_adv;
                    end
                end else begin
                    e_mod.mode      = M_TIMED;
                    e_mod.abs_start = st_adv;
                    e_mod.abs_dl    = dl_adv;
                end
            end
            F_BUDGET_OUT: begin
                if (r_ent.is_server) begin
                    e_mod.abs_dl = dl_adv;
                    ap_rearm     = 1'b1;
                end
            end
            F_NEW_JOB: begin
                if (r_ent.pending != PEND_MAX) begin
                    e_mod.pending = r_ent.pending + PEND_W'(1);
                end
                if (r_ent.mode == M_IDLE) begin
                    e_mod.mode = M_ACTIVE;
                    if (!(now_per < r_ent.abs_dl)) begin
                        e_mod.abs_dl = dl_adv;
                        ap_rearm     = 1'b1;
                    end
                end
            end
            default: e_mod = r_ent;
        endcase

        // row for a new task
        e_new.tag        = r_req.task_tag;
        e_new.period     = r_req.period;
        e_new.abs_start  = r_req.now;
        e_new.is_server  = r_req.is_server;
        e_new.max_budget = r_req.max_budget;
        e_new.pending    = '0;
        if (r_req.is_server) begin
            e_new.mode   = M_IDLE;
            e_new.abs_dl = r_req.now;
        end else begin
            e_new.mode   = M_ACTIVE;
            e_new.abs_dl = r_req.now + r_req.rel_deadline;
        end
    end

    // scan: wake a due timed task, then rank it
    t_mode mode_w;
    logic  take_next, take_start, take_run;

    always_comb begin
        mode_w = rd.mode;
        if (rd.mode == M_TIMED && rd.abs_start <= r_req.now) begin
            mode_w = M_ACTIVE;
        end
        take_next  = (mode_w == M_ACTIVE) && (!r_nv || rd.abs_dl < r_bdl);
        take_start = (mode_w == M_TIMED) && (!r_sv || rd.abs_start < r_st);
        take_run   = r_run_v && !r_rm_seen && (rd.tag == r_run_tag);
    end

    // table write port
    logic [CW-1:0] sh_idx;

    always_comb begin
        sh_idx = i_pidx - CW'(1);
        we     = 1'b0;
        waddr  = r_kidx;
        wdata  = e_mod;
        if (i_ctl.apply) begin
            if (r_req.func == F_ADD) begin
                we    = !table_full;
                waddr = r_cnt[IW-1:0];
                wdata = e_new;
            end else if (r_found && (tag_op || run_op) && r_req.func != F_REMOVE) begin
                we = 1'b1;
            end
        end else if (i_ctl.shift && i_ctl.ev_v) begin
            we    = 1'b1;
            waddr = sh_idx[IW-1:0];
            wdata = rd;
        end else if (i_ctl.scan && i_ctl.ev_v) begin
            we         = 1'b1;
            waddr      = i_pidx[IW-1:0];
            wdata      = rd;
            wdata.mode = mode_w;
        end
    end

    // final result
    logic susp;
    t_rsp rsp_new;

    always_comb begin
        susp                    = r_rm_seen && !(r_nv && r_nt == r_run_tag) && !r_rm_blk;
        rsp_new.add_status      = r_add_st;
        rsp_new.deadline_missed = r_missed;
        rsp_new.next_valid      = r_nv;
        rsp_new.next_tag        = r_nt;
        rsp_new.suspend_valid   = susp;
        rsp_new.suspend_tag     = susp ? r_run_tag : '0;
        rsp_new.start_valid     = r_sv;
        rsp_new.wake_time       = r_st;
        rsp_new.rearm_valid     = r_rearm_v;
        rsp_new.rearm_budget    = r_rearm_b;
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_run_v     <= 1'b0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (i_ctl.apply) begin
                if (r_req.func == F_ADD && !table_full) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                if (r_req.func == F_REMOVE && r_found) begin
                    r_cnt <= r_cnt - CW'(1);
                    if (r_run_v && r_run_tag == r_req.task_tag) begin
                        r_run_v <= 1'b0;
                    end
                end
            end
            if (i_ctl.fin) begin
                r_run_v     <= r_nv;
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req     <= i_req;
            r_found   <= 1'b0;
            r_add_st  <= ADD_NONE;
            r_missed  <= 1'b0;
            r_rearm_v <= 1'b0;
            r_rearm_b <= '0;
        end
        if (i_ctl.look && i_ctl.ev_v && !r_found && rd.tag == key) begin
            r_found <= 1'b1;
            r_kidx  <= i_pidx[IW-1:0];
            r_ent   <= rd;
        end
        if (i_ctl.apply) begin
            if (r_req.func == F_ADD) begin
                r_add_st <= table_full ? ADD_FULL : ADD_OK;
            end else if (r_found && run_op) begin
                r_missed  <= ap_missed;
                r_rearm_v <= ap_rearm;
                r_rearm_b <= ap_rearm ? r_ent.max_budget : '0;
            end else if (r_found && r_req.func == F_NEW_JOB) begin
                r_rearm_v <= ap_rearm;
                r_rearm_b <= ap_rearm ? r_ent.max_budget : '0;
            end
            r_nv      <= 1'b0;
            r_nt      <= '0;
            r_bdl     <= '0;
            r_sv      <= 1'b0;
            r_st      <= '0;
            r_rm_seen <= 1'b0;
            r_rm_blk  <= 1'b0;
        end
        if (i_ctl.scan && i_ctl.ev_v) begin
            if (take_next) begin
                r_nv  <= 1'b1;
                r_nt  <= rd.tag;
                r_bdl <= rd.abs_dl;
            end
            if (take_start) begin
                r_sv <= 1'b1;
                r_st <= rd.abs_start;
            end
            if (take_run) begin
                r_rm_seen <= 1'b1;
                r_rm_blk  <= (mode_w == M_BLOCKED);
            end
        end
        if (i_ctl.fin) begin
            r_run_tag <= r_nt;
            r_rsp     <= rsp_new;
        end
    end

    always_comb begin
        o_sts.hit       = !r_found && (rd.tag == key);
        o_sts.key_valid = key_valid;
        o_sts.shrink    = r_found && (r_req.func == F_REMOVE);
        o_sts.out_free  = !r_rsp_valid || i_rsp_ready;
    end

    assign o_cnt       = r_cnt;
    assign o_kidx      = r_kidx;
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_TASKS))
        else $error("task count beyond table size");

    a_remove_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.apply && r_found && r_req.func == F_REMOVE) |=>
        (r_cnt == $past(r_cnt) - CW'(1)))
        else $error("remove did not shrink table");

    a_next_tag_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_rsp_valid && !r_rsp.next_valid) |-> (r_rsp.next_tag == '0))
        else $error("next tag set without a chosen task");
endmodule

### hdl/edf_cbs_task_scheduler.sv
// Channel  | valid        | ready        | payload
// request  | i_req_valid  | o_req_ready  | i_req (t_req)
// response | o_rsp_valid  | i_rsp_ready  | o_rsp (t_rsp)
//
// One request at a time. Tag lookup, shift after a remove and selection
// scan each read one row per cycle from the task table, which has one
// read port and one write port. Events without a lookup (add, timeout,
// no running task) read no rows in the lookup phase.
// Reset clears the task count and the running task.
// A finished response waits in an output register; while it is not taken
// the next response stalls there, and the next request can be taken once
// a response has been placed.
module edf_cbs_task_scheduler #(
    parameter int MAX_TASKS = 16
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_req_valid,
    output logic           o_req_ready,
    input  ecbs_pkg::t_req i_req,
    output logic           o_rsp_valid,
    input  logic           i_rsp_ready,
    output ecbs_pkg::t_rsp o_rsp
);
    import ecbs_pkg::*;

    localparam int IW = $clog2(MAX_TASKS);
    localparam int CW = $clog2(MAX_TASKS + 1);

    t_ctl          ctl;
    t_sts          sts;
    logic [IW-1:0] raddr;
    logic [IW-1:0] kidx;
    logic [CW-1:0] pidx;
    logic [CW-1:0] cnt;

    ecbs_ctrl #(
        .MAX_TASKS (MAX_TASKS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_sts       (sts),
        .i_cnt       (cnt),
        .i_kidx      (kidx),
        .o_ctl       (ctl),
        .o_raddr     (raddr),
        .o_pidx      (pidx)
    );

    ecbs_dpath #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_raddr     (raddr),
        .i_pidx      (pidx),
        .i_req       (i_req),
        .o_sts       (sts),
        .o_cnt       (cnt),
        .o_kidx      (kidx),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp)
    );
endmodule

### sim/tb_edf_cbs_task_scheduler.sv
`timescale 1ns / 100ps

module tb_edf_cbs_task_scheduler;
    import ecbs_pkg::*;

    localparam int NTASK = 16;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int TAIL_CYCLES = 120;
    localparam int REQ_W = $bits(t_req);

    logic i_clk;
    logic i_rst_n;
    logic i_req_valid;
    logic o_req_ready;
    t_req i_req;
    logic o_rsp_valid;
    logic i_rsp_ready;
    t_rsp o_rsp;

    edf_cbs_task_scheduler #(.MAX_TASKS(NTASK)) u_top (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid),
        .o_req_ready(o_req_ready),
        .i_req(i_req),
        .o_rsp_valid(o_rsp_valid),
        .i_rsp_ready(i_rsp_ready),
        .o_rsp(o_rsp)
    );

    // shadow of the task table
    t_entry    sh_tab[NTASK];
    int        sh_count;
    logic      sh_run_v;
    logic [TAG_W-1:0] sh_run_tag;

    t_rsp      rsp_queue[$];
    int        errors;
    int        n_sent;
    int        n_checked;
    int        send_idle_pct;
    int        recv_idle_pct;
    logic      hold_rsp;
    int        idle_cycles;
    logic      timed_out;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int find_task(input logic [TAG_W-1:0] tag);
        for (int i = 0; i < sh_count; i++)
            if (sh_tab[i].tag == tag) return i;
        return -1;
    endfunction

    // predict the scheduler response and advance the shadow state
    function automatic t_rsp schedule_event(input t_req rq);
        t_rsp rs;
        int k;
        int r;
        logic [TIME_W-1:0] best;
        rs = '0;
        best = '0;
        case (rq.func)
            F_ADD: begin
                if (sh_count < NTASK) begin
                    sh_tab[sh_count].tag = rq.task_tag;
                    sh_tab[sh_count].period = rq.period;
                    sh_tab[sh_count].abs_start = rq.now;
                    sh_tab[sh_count].is_server = rq.is_server;
                    sh_tab[sh_count].max_budget = rq.max_budget;
                    sh_tab[sh_count].pending = '0;
                    if (rq.is_server) begin
                        sh_tab[sh_count].mode = M_IDLE;
                        sh_tab[sh_count].abs_dl = rq.now;
                    end else begin
                        sh_tab[sh_count].mode = M_ACTIVE;
                        sh_tab[sh_count].abs_dl = rq.now + rq.rel_deadline;
                    end
                    sh_count++;
                    rs.add_status = ADD_OK;
                end else begin
                    rs.add_status = ADD_FULL;
                end
            end
            F_REMOVE: begin
                k = find_task(rq.task_tag);
                if (k >= 0) begin
                    if (sh_run_v && sh_run_tag == rq.task_tag) sh_run_v = 1'b0;
                    sh_count--;
                    for (int i = k; i < sh_count; i++) sh_tab[i] = sh_tab[i+1];
                end
            end
            F_READY: begin
                k = find_task(rq.task_tag);
                if (k >= 0) sh_tab[k].mode = M_ACTIVE;
            end
            F_BLOCK: begin
                k = sh_run_v ? find_task(sh_run_tag) : -1;
                if (k >= 0) sh_tab[k].mode = M_BLOCKED;
            end
            F_END_JOB: begin
                k = sh_run_v ? find_task(sh_run_tag) : -1;
                if (k >= 0) begin
                    if (sh_tab[k].abs_dl < rq.now) rs.deadline_missed = 1'b1;
                    if (sh_tab[k].is_server) begin
                        if (sh_tab[k].pending > 0) sh_tab[k].pending--;
                        if (sh_tab[k].pending == 0) begin
                            sh_tab[k].mode = M_IDLE;
                            sh_tab[k].abs_start += sh_tab[k].period;
                            sh_tab[k].abs_dl += sh_tab[k].period;
                        end
                    end else begin
                        sh_tab[k].mode = M_TIMED;
                        sh_tab[k].abs_start += sh_tab[k].period;
                        sh_tab[k].abs_dl += sh_tab[k].period;
                    end
                end
            end
            F_BUDGET_OUT: begin
                k = sh_run_v ? find_task(sh_run_tag) : -1;
                if (k >= 0 && sh_tab[k].is_server) begin
                    sh_tab[k].abs_dl += sh_tab[k].period;
                    rs.rearm_valid = 1'b1;
                    rs.rearm_budget = sh_tab[k].max_budget;
                end
            end
            F_NEW_JOB: begin
                k = find_task(rq.task_tag);
                if (k >= 0) begin
                    if (sh_tab[k].pending != PEND_MAX) sh_tab[k].pending++;
                    if (sh_tab[k].mode == M_IDLE) begin
                        sh_tab[k].mode = M_ACTIVE;
                        if (!(TIME_W'(rq.now + sh_tab[k].period) < sh_tab[k].abs_dl))
                        begin
                            sh_tab[k].abs_dl += sh_tab[k].period;
                            rs.rearm_valid = 1'b1;
                            rs.rearm_budget = sh_tab[k].max_budget;
                        end
                    end
                end
            end
            default: ;
        endcase
        // wake due tasks, pick earliest deadline, track earliest start
        for (int i = 0; i < sh_count; i++) begin
            if (sh_tab[i].mode == M_TIMED && sh_tab[i].abs_start <= rq.now)
                sh_tab[i].mode = M_ACTIVE;
            if (sh_tab[i].mode == M_ACTIVE && (!rs.next_valid || sh_tab[i].abs_dl < best))
            begin
                rs.next_valid = 1'b1;
                best = sh_tab[i].abs_dl;
                rs.next_tag = sh_tab[i].tag;
            end
            if (sh_tab[i].mode == M_TIMED &&
                (!rs.start_valid || sh_tab[i].abs_start < rs.wake_time)) begin
                rs.start_valid = 1'b1;
                rs.wake_time = sh_tab[i].abs_start;
            end
        end
        r = sh_run_v ? find_task(sh_run_tag) : -1;
        if (r >= 0 && !(rs.next_valid && rs.next_tag == sh_run_tag) &&
            sh_tab[r].mode != M_BLOCKED) begin
            rs.suspend_valid = 1'b1;
            rs.suspend_tag = sh_run_tag;
        end
        sh_run_v = rs.next_valid;
        sh_run_tag = rs.next_tag;
        return rs;
    endfunction

    // send one request, predicting its response at acceptance
    task automatic send_request(input t_req rq);
        while (($urandom % 100) < send_idle_pct) @(posedge i_clk);
        i_req_valid <= 1'b1;
        i_req <= rq;
        @(posedge i_clk);
        while (!o_req_ready) @(posedge i_clk);
        rsp_queue.push_back(schedule_event(rq));
        n_sent++;
        i_req_valid <= 1'b0;
        // the block is busy after taking a request
        @(posedge i_clk);
    endtask

    function automatic t_req make_req(input t_func f, input logic [TIME_W-1:0] now,
                                      input logic [TAG_W-1:0] tag,
                                      input logic [TIME_W-1:0] per,
                                      input logic [TIME_W-1:0] rdl,
                                      input logic [TIME_W-1:0] mb, input logic srv);
        t_req rq;
        rq.func = f;
        rq.now = now;
        rq.task_tag = tag;
        rq.period = per;
        rq.rel_deadline = rdl;
        rq.max_budget = mb;
        rq.is_server = srv;
        return rq;
    endfunction

    function automatic logic [TIME_W-1:0] ticks(input int v);
        return TIME_W'(v);
    endfunction

    function automatic logic [TIME_W-1:0] rand_time();
        case ($urandom_range(0, 3))
            0: return TIME_W'({$urandom, $urandom});
            1: return TIME_W'($urandom_range(0, 40));
            2: return {TIME_W{1'b1}} - TIME_W'($urandom_range(0, 40));
            default: return TIME_W'($urandom_range(0, 5000));
        endcase
    endfunction

    task automatic wait_drained();
        while (rsp_queue.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    // response checker
    always @(posedge i_clk) begin
        t_rsp exp_rsp;
        if (i_rst_n && o_rsp_valid && i_rsp_ready) begin
            if (rsp_queue.size() == 0) begin
                $display("%0t: unexpected response %h", $time, o_rsp);
                errors++;
            end else begin
                exp_rsp = rsp_queue.pop_front();
                n_checked++;
                if (o_rsp.add_status !== exp_rsp.add_status)
                    $display("%0t: add_status exp %0d got %0d", $time,
                             exp_rsp.add_status, o_rsp.add_status);
                if (o_rsp.deadline_missed !== exp_rsp.deadline_missed)
                    $display("%0t: deadline_missed exp %0d got %0d", $time,
                             exp_rsp.deadline_missed, o_rsp.deadline_missed);
                if (o_rsp.next_valid !== exp_rsp.next_valid || o_rsp.next_tag !== exp_rsp.next_tag)
                    $display("%0t: next exp %0d/%0d got %0d/%0d", $time, exp_rsp.next_valid,
                             exp_rsp.next_tag, o_rsp.next_valid, o_rsp.next_tag);
                if (o_rsp.suspend_valid !== exp_rsp.suspend_valid ||
                    o_rsp.suspend_tag !== exp_rsp.suspend_tag)
                    $display("%0t: suspend exp %0d/%0d got %0d/%0d", $time,
                             exp_rsp.suspend_valid, exp_rsp.suspend_tag,
                             o_rsp.suspend_valid, o_rsp.suspend_tag);
                if (o_rsp.start_valid !== exp_rsp.start_valid ||
                    o_rsp.wake_time !== exp_rsp.wake_time)
                    $display("%0t: start exp %0d/%h got %0d/%h", $time, exp_rsp.start_valid,
                             exp_rsp.wake_time, o_rsp.start_valid, o_rsp.wake_time);
                if (o_rsp.rearm_valid !== exp_rsp.rearm_valid ||
                    o_rsp.rearm_budget !== exp_rsp.rearm_budget)
                    $display("%0t: rearm exp %0d/%h got %0d/%h", $time, exp_rsp.rearm_valid,
                             exp_rsp.rearm_budget, o_rsp.rearm_valid, o_rsp.rearm_budget);
                if (o_rsp !== exp_rsp) errors++;
            end
        end
    end

    // response-side stalls
    always @(posedge i_clk) begin
        if (!i_rst_n) i_rsp_ready <= 1'b0;
        else i_rsp_ready <= !hold_rsp && (($urandom % 100) >= recv_idle_pct);
    end

    // watchdog on cycles without any handshake
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_req_valid && o_req_ready) || (o_rsp_valid && i_rsp_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
            timed_out = 1'b1;
            $display("simulation failed");
            $finish;
        end
    end

    // directed: extremes, every event, table full, lookup misses
    task automatic test_directed();
        send_request(make_req(F_TIMEOUT, '0, '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_END_JOB, ticks(5), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_BLOCK, ticks(5), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_BUDGET_OUT, ticks(5), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_ADD, ticks(10), 8'hFF, ticks(100), '1, '1, 1'b0));
        send_request(make_req(F_ADD, ticks(10), 8'h00, '1, ticks(50), ticks(7), 1'b1));
        send_request(make_req(F_NEW_JOB, ticks(20), 8'h00, '0, '0, '0, 1'b0));
        send_request(make_req(F_BUDGET_OUT, ticks(21), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_END_JOB, ticks(30), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_END_JOB, '1, '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_BLOCK, ticks(40), '0, '0, '0, '0, 1'b0));
        send_request(make_req(F_READY, ticks(41), 8'hFF, '0, '0, '0, 1'b0));
        send_request(make_req(F_READY, ticks(41), 8'h55, '0, '0, '0, 1'b0));
        send_request(make_req(F_REMOVE, ticks(42), 8'h55, '0, '0, '0, 1'b0));
        for (int i = 0; i < 16; i++)
            send_request(make_req(F_ADD, ticks(i), TAG_W'(i), ticks(5), ticks(i),
                                  ticks(3), i[0]));
        send_request(make_req(F_REMOVE, ticks(60), 8'hFF, '0, '0, '0, 1'b0));
        send_request(make_req(F_REMOVE, ticks(61), 8'h00, '0, '0, '0, 1'b0));
    endtask

    // random: mostly valid tags from a small pool, occasional noise
    task automatic test_random(input int count);
        t_req rq;
        int pick;
        for (int n = 0; n < count; n++) begin
            rq = REQ_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
            pick = $urandom_range(0, 99);
            if (pick < 20) rq.func = F_ADD;
            else if (pick < 30) rq.func = F_REMOVE;
            else if (pick < 42) rq.func = F_READY;
            else if (pick < 52) rq.func = F_BLOCK;
            else if (pick < 70) rq.func = F_END_JOB;
            else if (pick < 78) rq.func = F_BUDGET_OUT;
            else if (pick < 94) rq.func = F_NEW_JOB;
            else rq.func = F_TIMEOUT;
            if ($urandom_range(0, 9) != 0) rq.task_tag = TAG_W'($urandom_range(0, 11));
            rq.now = rand_time();
            rq.period = rand_time();
            rq.rel_deadline = rand_time();
            rq.max_budget = rand_time();
            send_request(rq);
        end
    endtask

    // hold the response side long enough to back up the request side
    task automatic test_backpressure();
        hold_rsp <= 1'b1;
        fork
            begin
                repeat (400) @(posedge i_clk);
                hold_rsp <= 1'b0;
            end
            test_random(12);
        join
        wait_drained();
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        hold_rsp = 1'b0;
        timed_out = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        send_idle_pct = 14;
        recv_idle_pct = 65;
        for (int i = 0; i < NTASK; i++) sh_tab[i] = '0;
        sh_count = 0;
        sh_run_v = 1'b0;
        sh_run_tag = '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        wait_drained();
        test_random(500);
        test_backpressure();
        send_idle_pct = 65;
        recv_idle_pct = 14;
        test_random(500);
        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(520);
        wait_drained();

        $display("Sent %0d scheduling events, checked %0d responses,", n_sent, n_checked);
        $display("across all event kinds, a full table, stalls and back-pressure.");
        if (errors == 0 && rsp_queue.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

### filelist.f
hdl/ecbs_pkg.sv
hdl/ecbs_ram.sv
hdl/ecbs_ctrl.sv
hdl/ecbs_dpath.sv
hdl/edf_cbs_task_scheduler.sv
sim/tb_edf_cbs_task_scheduler.sv
